### sv/hpe_pkg.sv
package hpe_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_TERMS = 7;
  localparam int NUM_STEPS = MAX_TERMS - 1;
  localparam int TERM_W    = 3;
  localparam int IDX_W     = 3;
  localparam int WIDE_W    = 2 * WORD_W;
  localparam int PIPE_LAT  = 1 + 2 * NUM_STEPS;

  localparam logic [IDX_W-1:0] REG_NUM_TERMS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COEF_BASE = IDX_W'(1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic [TERM_W-1:0]        term_cnt_t;
  typedef logic [IDX_W-1:0]         reg_idx_t;

  localparam wide_t WIDE_MAX = {{(WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam wide_t WIDE_MIN = ~WIDE_MAX;

  typedef struct packed {
    logic  valid;
    logic  flag;
    word_t x;
    word_t acc;
  } lane_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } sat_t;

  function automatic sat_t sat_word(input wide_t v);
    sat_t r;
    r.sat = 1'b0;
    r.val = v[WORD_W-1:0];
    if (v > WIDE_MAX) begin
      r.sat = 1'b1;
      r.val = WIDE_MAX[WORD_W-1:0];
    end else if (v < WIDE_MIN) begin
      r.sat = 1'b1;
      r.val = WIDE_MIN[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/hpe_cfg.sv
module hpe_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  hpe_pkg::reg_idx_t   cfg_index,
  input  hpe_pkg::word_t      cfg_data,
  output hpe_pkg::term_cnt_t  num_terms,
  output hpe_pkg::word_t      coef [hpe_pkg::MAX_TERMS]
);
  import hpe_pkg::*;

  term_cnt_t num_terms_r;
  word_t     coef_r [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_terms_r <= '0;
      for (int i = 0; i < MAX_TERMS; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_TERMS) begin
        num_terms_r <= cfg_data[TERM_W-1:0];
      end else begin
        for (int i = 0; i < MAX_TERMS; i++) begin
          if (cfg_index == REG_COEF_BASE + IDX_W'(i)) coef_r[i] <= cfg_data;
        end
      end
    end
  end

  assign num_terms = num_terms_r;
  assign coef      = coef_r;

  a_terms_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_we && cfg_index == REG_NUM_TERMS) |-> $stable(num_terms_r))
    else $error("term count changed without a write");

  a_coef0_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_we && cfg_index == REG_COEF_BASE) |-> $stable(coef_r[0]))
    else $error("constant term changed without a write");

  a_terms_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_NUM_TERMS |=> num_terms_r == $past(cfg_data[TERM_W-1:0]))
    else $error("term count write lost");

endmodule

### sv/hpe_step.sv
module hpe_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           active,
  input  hpe_pkg::word_t coef,
  input  hpe_pkg::lane_t lane_in,
  output hpe_pkg::lane_t lane_out
);
  import hpe_pkg::*;

  // stage A: product
  logic  valid_a_r;
  logic  flag_a_r;
  word_t x_a_r;
  word_t acc_a_r;
  wide_t prod_a_r;
  wide_t prod_nxt;

  // stage B: scale, saturate, add
  lane_t lane_b_r;
  lane_t lane_b_nxt;
  sat_t  prod_sat;
  sat_t  sum_sat;
  wide_t sum_wide;

  assign prod_nxt = $signed(lane_in.acc) * $signed(lane_in.x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= lane_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    flag_a_r <= lane_in.flag;
    x_a_r    <= lane_in.x;
    acc_a_r  <= lane_in.acc;
    prod_a_r <= prod_nxt;
  end

  always_comb begin
    prod_sat = sat_word(prod_a_r >>> FRAC_BITS);
    sum_wide = WIDE_W'(prod_sat.val) + WIDE_W'(coef);
    sum_sat  = sat_word(sum_wide);
    lane_b_nxt.valid = valid_a_r;
    lane_b_nxt.x     = x_a_r;
    lane_b_nxt.acc   = active ? sum_sat.val : acc_a_r;
    lane_b_nxt.flag  = flag_a_r | (active & (prod_sat.sat | sum_sat.sat));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_b_r.valid <= 1'b0;
    end else begin
      lane_b_r.valid <= lane_b_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    lane_b_r.flag <= lane_b_nxt.flag;
    lane_b_r.x    <= lane_b_nxt.x;
    lane_b_r.acc  <= lane_b_nxt.acc;
  end

  assign lane_out = lane_b_r;

  a_valid_lat: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(rst_n, 2) |-> lane_out.valid == $past(lane_in.valid, 2))
    else $error("valid lost or invented in step");

  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(rst_n, 2) && $past(lane_in.valid && lane_in.flag, 2)
    |-> lane_out.flag)
    else $error("saturation flag dropped");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(active) && $past(valid_a_r) |-> lane_out.acc == $past(acc_a_r))
    else $error("idle step altered accumulator");

endmodule

### sv/polynomial_evaluator.sv
// Horner polynomial evaluator, signed Q16.16. One sample is taken per clock
// (start while busy is low); busy is high only in reset and the cycle after it.
// Each sample with num_terms above zero yields one result, marked by out_valid
// for one cycle. It passes an entry register that picks the highest
// coefficient in use, then six Horner steps of two registers each (multiply,
// then scale, saturate and add). Fewer terms pass through unused steps, so
// latency does not depend on num_terms. With num_terms at zero a sample is
// taken but produces no result. Results cannot be held off by the receiver.
module polynomial_evaluator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hpe_pkg::word_t    in_sample_x,
  output logic              out_valid,
  output hpe_pkg::word_t    out_value_y,
  output logic              out_saturated,
  input  logic              cfg_we,
  input  hpe_pkg::reg_idx_t cfg_index,
  input  hpe_pkg::word_t    cfg_data
);
  import hpe_pkg::*;

  term_cnt_t num_terms;
  word_t     coef [MAX_TERMS];
  logic      ready_r;
  logic      in_accept;
  lane_t     lane [NUM_STEPS+1];
  lane_t     lane0_r;
  lane_t     lane0_nxt;
  logic      step_active [NUM_STEPS];

  hpe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .num_terms (num_terms),
    .coef      (coef)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign busy      = ~ready_r;
  assign in_accept = start & ~busy;

  always_comb begin
    lane0_nxt.valid = in_accept && (num_terms != '0);
    lane0_nxt.flag  = 1'b0;
    lane0_nxt.x     = in_sample_x;
    lane0_nxt.acc   = coef[num_terms - TERM_W'(1)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane0_r.valid <= 1'b0;
    end else begin
      lane0_r.valid <= lane0_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    lane0_r.flag <= lane0_nxt.flag;
    lane0_r.x    <= lane0_nxt.x;
    lane0_r.acc  <= lane0_nxt.acc;
  end

  assign lane[0] = lane0_r;

  // step i handles coefficient NUM_STEPS-1-i
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    assign step_active[i] = (int'(num_terms) >= NUM_STEPS + 1 - i);

    hpe_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .active   (step_active[i]),
      .coef     (coef[NUM_STEPS-1-i]),
      .lane_in  (lane[i]),
      .lane_out (lane[i+1])
    );
  end

  assign out_valid     = lane[NUM_STEPS].valid;
  assign out_value_y   = lane[NUM_STEPS].acc;
  assign out_saturated = lane[NUM_STEPS].flag;

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, PIPE_LAT))
    else $error("result word without accepted sample");

  a_busy_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> busy)
    else $error("busy low right after reset");

  a_no_out_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !lane0_r.valid)
    else $error("entry stage valid after reset");

endmodule
